FILE: design/cimr_pkg.sv
// ----------------------------------------------------------------------------
// cimr_pkg
// Shared widths, register indexes, status codes and pipeline types for the
// camera intrinsics remapper.
// ----------------------------------------------------------------------------
package cimr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SIZE_BITS  = 14;
  localparam int DATA_W     = 32;
  localparam int NUM_W      = 48;
  localparam int DEN_W      = SIZE_BITS + 1;
  localparam int K_W        = 5;
  localparam int SQ_W       = 2 * SIZE_BITS + 1;
  localparam int CMP_W      = 4 * SIZE_BITS + 1;
  localparam int NK         = 2 * SIZE_BITS;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DATA_W / DIV_STEPS;
  localparam int DIV_LAT    = DIV_STAGES + 2;
  localparam int FRONT      = 6;
  localparam int TAIL       = 3 * DIV_LAT;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_SENSOR_WIDTH  = 3'd0;
  localparam reg_idx_t REG_SENSOR_HEIGHT = 3'd1;
  localparam reg_idx_t REG_ISP_WIDTH     = 3'd2;
  localparam reg_idx_t REG_ISP_HEIGHT    = 3'd3;
  localparam reg_idx_t REG_OUT_WIDTH     = 3'd4;
  localparam reg_idx_t REG_OUT_HEIGHT    = 3'd5;
  localparam reg_idx_t REG_CROP_MODE     = 3'd6;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UNSET  = 2'd1,
    ST_EXCEED = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] fx;
    logic signed [DATA_W-1:0] fy;
    logic signed [DATA_W-1:0] cx;
    logic signed [DATA_W-1:0] cy;
    logic [SIZE_BITS-1:0]     cw;
    logic [SIZE_BITS-1:0]     ch;
  } item_t;

  typedef struct packed {
    logic                  valid;
    logic signed [K_W-1:0] k;
  } side_t;

endpackage

FILE: design/camera_intrinsics_mode_remap.sv
// ----------------------------------------------------------------------------
// camera_intrinsics_mode_remap
// Remaps pinhole intrinsics from the calibration frame to the sensor mode,
// the ISP frame and the published frame.
// ----------------------------------------------------------------------------
// One item per cycle unless held. Six front stages pick plain scale or binned
// window and the binning exponent; three ranks of four pipelined dividers
// (ten stages each, four quotient bits per divide stage) do the sensor, ISP
// and output scaling; one output register holds the result. The pipeline
// moves as one; it stops only when the output register is held and an item
// waits at the last divider stage. Configuration writes are taken at once.
module camera_intrinsics_mode_remap import cimr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic signed [31:0]       focal_x_in,
  input  logic signed [31:0]       focal_y_in,
  input  logic signed [31:0]       center_x_in,
  input  logic signed [31:0]       center_y_in,
  input  logic [SIZE_BITS-1:0]     calib_width,
  input  logic [SIZE_BITS-1:0]     calib_height,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output logic signed [31:0]       focal_x_out,
  output logic signed [31:0]       focal_y_out,
  output logic signed [31:0]       center_x_out,
  output logic signed [31:0]       center_y_out,
  output logic signed [K_W-1:0]    binning_shift,
  output logic [1:0]               status,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  reg_idx_t                 cfg_index,
  input  logic [SIZE_BITS-1:0]     cfg_data
);

  function automatic logic [NUM_W-1:0] sx(input logic [DATA_W-1:0] v);
    sx = {{(NUM_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  // configuration
  logic [SIZE_BITS-1:0] sensor_width, sensor_height, isp_width, isp_height;
  logic [SIZE_BITS-1:0] out_width, out_height;
  logic                 crop_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_width  <= '0;
      sensor_height <= '0;
      isp_width     <= '0;
      isp_height    <= '0;
      out_width     <= '0;
      out_height    <= '0;
      crop_mode     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SENSOR_WIDTH:  sensor_width  <= cfg_data;
        REG_SENSOR_HEIGHT: sensor_height <= cfg_data;
        REG_ISP_WIDTH:     isp_width     <= cfg_data;
        REG_ISP_HEIGHT:    isp_height    <= cfg_data;
        REG_OUT_WIDTH:     out_width     <= cfg_data;
        REG_OUT_HEIGHT:    out_height    <= cfg_data;
        REG_CROP_MODE:     crop_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [SIZE_BITS-1:0] iw, ih;
  logic                 unset, exceed;
  assign iw     = (isp_width  != '0) ? isp_width  : sensor_width;
  assign ih     = (isp_height != '0) ? isp_height : sensor_height;
  assign unset  = (sensor_width == '0) || (sensor_height == '0);
  assign exceed = crop_mode && ((out_width > iw) || (out_height > ih));

  // pipeline control
  side_t side [0:TAIL-1];
  logic  en;

  assign en        = !rsp_valid || rsp_ready || !side[TAIL-1].valid;
  assign req_ready = en;

  // front stages
  logic  v    [0:FRONT-1];
  item_t item [0:FRONT-1];

  logic [2*SIZE_BITS-1:0] lhs1, rhs1;
  logic                   match2, match3, match4, match5;
  logic [SIZE_BITS-1:0]   p2, q2;
  logic [SQ_W-1:0]        a3;
  logic [SQ_W-2:0]        b3;
  logic [NK-1:0]          ge4;
  logic signed [K_W-1:0]  k5;

  logic [2*SIZE_BITS-1:0] diff;
  logic [2*SIZE_BITS+6:0] diff100;
  logic [NK-1:0]          ge;
  logic signed [K_W-1:0]  kenc;

  always_comb begin
    diff    = (lhs1 > rhs1) ? (lhs1 - rhs1) : (rhs1 - lhs1);
    diff100 = (2*SIZE_BITS+7)'(diff) * (2*SIZE_BITS+7)'(100);
  end

  always_comb begin
    int kk;
    for (int j = 0; j < NK; j++) begin
      kk = SIZE_BITS - j;
      if (kk >= 0) begin
        ge[j] = (CMP_W'(a3) >= (CMP_W'(b3) << (2 * kk)));
      end else begin
        ge[j] = ((CMP_W'(a3) << (-2 * kk)) >= CMP_W'(b3));
      end
    end
  end

  always_comb begin
    kenc = K_W'(-SIZE_BITS);
    for (int j = NK - 1; j >= 0; j--) begin
      if (ge4[j]) begin
        kenc = K_W'(SIZE_BITS - j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRONT; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= req_valid;
      for (int i = 1; i < FRONT; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item[0].fx <= focal_x_in;
      item[0].fy <= focal_y_in;
      item[0].cx <= center_x_in;
      item[0].cy <= center_y_in;
      item[0].cw <= (calib_width  == '0) ? SIZE_BITS'(1) : calib_width;
      item[0].ch <= (calib_height == '0) ? SIZE_BITS'(1) : calib_height;
      for (int i = 1; i < FRONT; i++) begin
        item[i] <= item[i-1];
      end
      lhs1   <= (2*SIZE_BITS)'(item[0].cw) * (2*SIZE_BITS)'(sensor_height);
      rhs1   <= (2*SIZE_BITS)'(item[0].ch) * (2*SIZE_BITS)'(sensor_width);
      match2 <= diff100 < (2*SIZE_BITS+7)'(lhs1);
      p2     <= (lhs1 <= rhs1) ? item[1].cw : item[1].ch;
      q2     <= (lhs1 <= rhs1) ? sensor_width : sensor_height;
      match3 <= match2;
      a3     <= SQ_W'(p2) * SQ_W'(p2) << 1;
      b3     <= (SQ_W-1)'(q2) * (SQ_W-1)'(q2);
      match4 <= match3;
      ge4    <= ge;
      match5 <= match4;
      k5     <= match4 ? K_W'(0) : kenc;
    end
  end

  // sensor mode numerators
  logic [K_W-2:0]   pos, neg;
  logic [K_W-1:0]   kneg;
  logic [NUM_W-1:0] n1 [0:3];
  logic [DEN_W-1:0] d1 [0:3];

  always_comb begin
    kneg = K_W'(-k5);
    pos  = (k5 > 0) ? k5[K_W-2:0] : '0;
    neg  = (k5 < 0) ? kneg[K_W-2:0] : '0;
    if (match5) begin
      n1[0] = NUM_W'(item[FRONT-1].fx * $signed({1'b0, sensor_width}));
      n1[1] = NUM_W'(item[FRONT-1].fy * $signed({1'b0, sensor_height}));
      n1[2] = NUM_W'(item[FRONT-1].cx * $signed({1'b0, sensor_width}));
      n1[3] = NUM_W'(item[FRONT-1].cy * $signed({1'b0, sensor_height}));
      d1[0] = DEN_W'(item[FRONT-1].cw);
      d1[1] = DEN_W'(item[FRONT-1].ch);
      d1[2] = DEN_W'(item[FRONT-1].cw);
      d1[3] = DEN_W'(item[FRONT-1].ch);
    end else begin
      n1[0] = sx(item[FRONT-1].fx) << neg;
      n1[1] = sx(item[FRONT-1].fy) << neg;
      n1[2] = (sx(item[FRONT-1].cx) << neg)
            - (NUM_W'(item[FRONT-1].cw) << (FRAC_BITS - 1 + int'(neg)))
            + (NUM_W'(sensor_width) << (FRAC_BITS - 1 + int'(pos)));
      n1[3] = (sx(item[FRONT-1].cy) << neg)
            - (NUM_W'(item[FRONT-1].ch) << (FRAC_BITS - 1 + int'(neg)))
            + (NUM_W'(sensor_height) << (FRAC_BITS - 1 + int'(pos)));
      for (int i = 0; i < 4; i++) begin
        d1[i] = DEN_W'(1) << pos;
      end
    end
  end

  logic signed [DATA_W-1:0] r1 [0:3];
  logic signed [DATA_W-1:0] r2 [0:3];
  logic signed [DATA_W-1:0] r3 [0:3];
  logic [NUM_W-1:0]         n2 [0:3];
  logic [DEN_W-1:0]         d2 [0:3];
  logic [NUM_W-1:0]         n3 [0:3];
  logic [DEN_W-1:0]         d3 [0:3];

  // ISP numerators
  always_comb begin
    n2[0] = NUM_W'(r1[0] * $signed({1'b0, iw}));
    n2[1] = NUM_W'(r1[1] * $signed({1'b0, ih}));
    n2[2] = NUM_W'(r1[2] * $signed({1'b0, iw}));
    n2[3] = NUM_W'(r1[3] * $signed({1'b0, ih}));
    d2[0] = DEN_W'(sensor_width);
    d2[1] = DEN_W'(sensor_height);
    d2[2] = DEN_W'(sensor_width);
    d2[3] = DEN_W'(sensor_height);
  end

  // output numerators
  logic [SIZE_BITS-1:0] offx, offy;

  always_comb begin
    offx = SIZE_BITS'(iw - out_width) >> 1;
    offy = SIZE_BITS'(ih - out_height) >> 1;
    if (crop_mode) begin
      n3[0] = sx(r2[0]);
      n3[1] = sx(r2[1]);
      n3[2] = sx(r2[2]) - (NUM_W'(offx) << FRAC_BITS);
      n3[3] = sx(r2[3]) - (NUM_W'(offy) << FRAC_BITS);
      for (int i = 0; i < 4; i++) begin
        d3[i] = DEN_W'(1);
      end
    end else begin
      n3[0] = NUM_W'(r2[0] * $signed({1'b0, out_width}));
      n3[1] = NUM_W'(r2[1] * $signed({1'b0, out_height}));
      n3[2] = NUM_W'(r2[2] * $signed({1'b0, out_width}));
      n3[3] = NUM_W'(r2[3] * $signed({1'b0, out_height}));
      d3[0] = DEN_W'(iw);
      d3[1] = DEN_W'(ih);
      d3[2] = DEN_W'(iw);
      d3[3] = DEN_W'(ih);
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    cimr_div u_div_sensor (
      .clk (clk),
      .en  (en),
      .num (n1[l]),
      .den (d1[l]),
      .quo (r1[l])
    );
    cimr_div u_div_isp (
      .clk (clk),
      .en  (en),
      .num (n2[l]),
      .den (d2[l]),
      .quo (r2[l])
    );
    cimr_div u_div_out (
      .clk (clk),
      .en  (en),
      .num (n3[l]),
      .den (d3[l]),
      .quo (r3[l])
    );
  end

  // valid and binning exponent alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAIL; i++) begin
        side[i].valid <= 1'b0;
      end
    end else if (en) begin
      side[0].valid <= v[FRONT-1];
      for (int i = 1; i < TAIL; i++) begin
        side[i].valid <= side[i-1].valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0].k <= k5;
      for (int i = 1; i < TAIL; i++) begin
        side[i].k <= side[i-1].k;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en && side[TAIL-1].valid) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && side[TAIL-1].valid) begin
      if (unset) begin
        focal_x_out   <= '0;
        focal_y_out   <= '0;
        center_x_out  <= '0;
        center_y_out  <= '0;
        binning_shift <= '0;
        status        <= ST_UNSET;
      end else if (exceed) begin
        focal_x_out   <= '0;
        focal_y_out   <= '0;
        center_x_out  <= '0;
        center_y_out  <= '0;
        binning_shift <= side[TAIL-1].k;
        status        <= ST_EXCEED;
      end else begin
        focal_x_out   <= r3[0];
        focal_y_out   <= r3[1];
        center_x_out  <= r3[2];
        center_y_out  <= r3[3];
        binning_shift <= side[TAIL-1].k;
        status        <= ST_OK;
      end
    end
  end

`ifndef ASSERT_OFF
  a_unset_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_UNSET) |->
      (focal_x_out == '0) && (center_y_out == '0) && (binning_shift == '0))
    else $error("unset sensor size gave nonzero result");

  a_exceed_crop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_EXCEED) |-> crop_mode)
    else $error("exceed status outside crop mode");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready && side[TAIL-1].valid |-> !req_ready)
    else $error("item accepted while pipeline held");
`endif

endmodule

FILE: design/cimr_div.sv
// ----------------------------------------------------------------------------
// cimr_div
// Pipelined signed divide by an unsigned divisor, rounded to nearest with
// ties away from zero, saturated to 32 bits. Four quotient bits per stage.
// ----------------------------------------------------------------------------
module cimr_div import cimr_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [NUM_W-1:0]         num,
  input  logic [DEN_W-1:0]         den,
  output logic signed [DATA_W-1:0] quo
);

  logic [DEN_W-1:0]  rem  [0:DIV_STAGES];
  logic [DATA_W-1:0] w    [0:DIV_STAGES];
  logic [DEN_W-1:0]  d    [0:DIV_STAGES];
  logic              sgn  [0:DIV_STAGES];
  logic              ovf  [0:DIV_STAGES];

  logic [NUM_W-1:0]  mag;
  logic [NUM_W-1:0]  magr;
  logic [NUM_W-DATA_W-1:0] hi;

  always_comb begin
    mag  = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
    magr = mag + NUM_W'(den >> 1);
    hi   = magr[NUM_W-1:DATA_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= hi[DEN_W-1:0];
      w[0]   <= magr[DATA_W-1:0];
      d[0]   <= den;
      sgn[0] <= num[NUM_W-1];
      ovf[0] <= (hi >= (NUM_W-DATA_W)'(den));
    end
  end

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
    logic [DEN_W-1:0]  r_out;
    logic [DATA_W-1:0] w_out;

    always_comb begin
      logic [DEN_W:0] r;
      r_out = rem[s-1];
      w_out = w[s-1];
      for (int i = 0; i < DIV_STEPS; i++) begin
        r     = {r_out, w_out[DATA_W-1]};
        w_out = {w_out[DATA_W-2:0], 1'b0};
        if (r >= {1'b0, d[s-1]}) begin
          r        = r - {1'b0, d[s-1]};
          w_out[0] = 1'b1;
        end
        r_out = r[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= r_out;
        w[s]   <= w_out;
        d[s]   <= d[s-1];
        sgn[s] <= sgn[s-1];
        ovf[s] <= ovf[s-1];
      end
    end
  end

  logic [DATA_W-1:0] q;
  logic signed [DATA_W-1:0] quo_next;

  always_comb begin
    q = w[DIV_STAGES];
    if (!sgn[DIV_STAGES]) begin
      if (ovf[DIV_STAGES] || q[DATA_W-1]) begin
        quo_next = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        quo_next = $signed(q);
      end
    end else begin
      if (ovf[DIV_STAGES] || (q[DATA_W-1] && |q[DATA_W-2:0])) begin
        quo_next = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        quo_next = $signed(~q + DATA_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= quo_next;
    end
  end

endmodule
